// ----- src/fdre_pkg.sv -----
// Shared types and constants of the frame delta run-length encoder.
// Used by fdre_ctrl, fdre_datapath and frame_delta_rle_encoder_top; depends on nothing.
`default_nettype none

package fdre_pkg;

    // Width of the frame size register, and of the changed-pixel counter.
    localparam int FP_W = 22;

    // Run value that marks a run of unchanged pixels.
    localparam logic [15:0] SKIP_MARK = 16'hFFFF;

    // Prefix of every length byte (10xxxxxx); six length bits follow it.
    localparam logic [1:0] LEN_TAG = 2'b10;
    localparam int         LEN_GROUP_W = 6;

    // Reset value of the frame size register and saturation limit of the count.
    localparam logic [FP_W-1:0] FRAME_PIXELS_RESET = 22'd2097152;
    localparam logic [FP_W-1:0] COUNT_MAX = 22'h3FFFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_pixel;   // capture the pixel and read its reference entry
        logic restart;      // clear reference fill, position, run and count
        logic compare;      // compare with the reference, update the entry
        logic append;       // extend or open the run with the pixel's value
        logic advance;      // step to the next pixel position
        logic flush_start;  // load the length shifter from the run length
        logic emit_len;     // send one length group
        logic emit_hi;      // send the colour high byte, update the count
        logic emit_lo;      // send the low byte and close the run
        logic item_last;    // the byte sent now is the last one of the item
        logic end_frame;    // the byte sent now closes the frame
        logic frame_done;   // clear position, run and count after the frame
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_flush;   // the open run ends before this pixel
        logic last;         // the current position is the frame's last pixel
        logic len_needed;   // the open run sends its length first
        logic run_colour;   // the open run is a colour run
        logic len_done;     // the length group in the shifter is the last one
        logic out_free;     // the output register can take a byte this cycle
    } status_t;

endpackage

`default_nettype wire

// ----- src/fdre_datapath.sv -----
// Datapath of the frame delta run-length encoder: reference frame memory, run state,
// length shifter, changed-pixel counter and the output register. Uses fdre_pkg.
`default_nettype none

module fdre_datapath #(
    parameter int MAX_FRAME_PIXELS = 2097152
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire fdre_pkg::cmd_t              cmd,
    output fdre_pkg::status_t                status,
    input  wire logic [23:0]                 s_tdata,
    input  wire logic                        cfg_we,
    input  wire logic [fdre_pkg::FP_W-1:0]   cfg_wdata,
    input  wire logic                        m_tready,
    output logic                             m_tvalid,
    output logic [31:0]                      m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast
);

    localparam int AW = $clog2(MAX_FRAME_PIXELS);
    localparam int RW = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int CW = (RW > fdre_pkg::FP_W) ? RW : fdre_pkg::FP_W;
    localparam int SW = CW + 1;

    // Reference frame; the fill count marks how far it has been written since a clear.
    logic [23:0] ref_mem [MAX_FRAME_PIXELS];

    logic [fdre_pkg::FP_W-1:0] frame_pixels_reg, frame_pixels_next;
    logic [AW-1:0]             pos_reg, pos_next;
    logic [RW-1:0]             fill_reg, fill_next;
    logic [15:0]               run_value_reg, run_value_next;
    logic [RW-1:0]             run_length_reg, run_length_next;
    logic [fdre_pkg::FP_W-1:0] changed_reg, changed_next;
    logic                      out_valid_reg, out_valid_next;

    logic [23:0]               rgb_reg, rgb_next;
    logic [23:0]               rd_data_reg;
    logic [15:0]               c_reg, c_next;
    logic [RW-1:0]             len_reg, len_next;
    logic [7:0]                out_byte_reg, out_byte_next;
    logic [fdre_pkg::FP_W-1:0] out_changed_reg, out_changed_next;
    logic                      out_user_reg, out_user_next;
    logic                      out_last_reg, out_last_next;

    logic [RW-1:0]             pos_ext;
    logic [23:0]               ref_value;
    logic [15:0]               c_comb;
    logic [15:0]               c_sel;
    logic [CW-1:0]             fp_ext;
    logic [CW-1:0]             fp_eff;
    logic [CW-1:0]             pos_plus_one;
    logic [SW-1:0]             count_sum;
    logic [fdre_pkg::FP_W-1:0] count_sat;
    logic [5:0]                len_group;

    always_ff @(posedge aclk) begin
        if (cmd.compare) begin
            ref_mem[pos_reg] <= rgb_reg;
        end
        if (cmd.load_pixel) begin
            rd_data_reg <= ref_mem[pos_reg];
        end
    end

    always_comb begin
        pos_ext   = RW'(pos_reg);
        // Entries at or beyond the fill count have not been written since the last clear.
        ref_value = (pos_ext < fill_reg) ? rd_data_reg : 24'd0;
        if (ref_value != rgb_reg) begin
            c_comb = {1'b0, rgb_reg[23:19], rgb_reg[15:11], rgb_reg[7:3]};
        end else begin
            c_comb = fdre_pkg::SKIP_MARK;
        end
        c_sel = cmd.compare ? c_comb : c_reg;

        fp_ext = CW'(frame_pixels_reg);
        if (fp_ext == '0) begin
            fp_eff = CW'(1);
        end else if (fp_ext > CW'(MAX_FRAME_PIXELS)) begin
            fp_eff = CW'(MAX_FRAME_PIXELS);
        end else begin
            fp_eff = fp_ext;
        end
        pos_plus_one = CW'(pos_reg) + CW'(1);

        count_sum = SW'(changed_reg) + SW'(run_length_reg);
        if (count_sum > SW'(fdre_pkg::COUNT_MAX)) begin
            count_sat = fdre_pkg::COUNT_MAX;
        end else begin
            count_sat = count_sum[fdre_pkg::FP_W-1:0];
        end

        len_group = 6'(len_reg);

        status.need_flush = (pos_reg != '0) && (c_comb != run_value_reg)
                            && (run_length_reg != '0);
        status.last       = (pos_plus_one >= fp_eff);
        status.len_needed = (run_length_reg > RW'(1)) || (run_value_reg == fdre_pkg::SKIP_MARK);
        status.run_colour = (run_value_reg != fdre_pkg::SKIP_MARK);
        status.len_done   = ((len_reg >> fdre_pkg::LEN_GROUP_W) == '0);
        status.out_free   = !out_valid_reg || m_tready;
    end

    always_comb begin
        frame_pixels_next = frame_pixels_reg;
        pos_next          = pos_reg;
        fill_next         = fill_reg;
        run_value_next    = run_value_reg;
        run_length_next   = run_length_reg;
        changed_next      = changed_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        rgb_next          = rgb_reg;
        c_next            = c_reg;
        len_next          = len_reg;
        out_byte_next     = out_byte_reg;
        out_changed_next  = out_changed_reg;
        out_user_next     = out_user_reg;
        out_last_next     = out_last_reg;

        if (cfg_we) begin
            frame_pixels_next = cfg_wdata;
        end
        if (cmd.load_pixel) begin
            rgb_next = s_tdata;
        end
        if (cmd.restart) begin
            pos_next        = '0;
            fill_next       = '0;
            run_value_next  = fdre_pkg::SKIP_MARK;
            run_length_next = '0;
            changed_next    = '0;
        end
        if (cmd.compare) begin
            c_next = c_comb;
            if (pos_ext == fill_reg) begin
                fill_next = fill_reg + RW'(1);
            end
        end
        if (cmd.append) begin
            if (run_length_reg == '0) begin
                run_value_next = c_sel;
            end
            run_length_next = run_length_reg + RW'(1);
        end
        if (cmd.advance) begin
            pos_next = pos_reg + AW'(1);
        end
        if (cmd.flush_start) begin
            len_next = run_length_reg;
        end
        if (cmd.emit_len) begin
            len_next      = len_reg >> fdre_pkg::LEN_GROUP_W;
            out_byte_next = {fdre_pkg::LEN_TAG, len_group};
        end
        if (cmd.emit_hi) begin
            changed_next  = count_sat;
            out_byte_next = run_value_reg[15:8];
        end
        if (cmd.emit_lo) begin
            run_length_next = '0;
            out_byte_next   = run_value_reg[7:0];
        end
        if (cmd.emit_len || cmd.emit_hi || cmd.emit_lo) begin
            out_valid_next   = 1'b1;
            out_user_next    = cmd.item_last;
            out_last_next    = cmd.end_frame;
            out_changed_next = cmd.end_frame ? changed_reg : '0;
        end
        if (cmd.frame_done) begin
            pos_next        = '0;
            run_value_next  = fdre_pkg::SKIP_MARK;
            run_length_next = '0;
            changed_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pixels_reg <= fdre_pkg::FRAME_PIXELS_RESET;
            pos_reg          <= '0;
            fill_reg         <= '0;
            run_value_reg    <= fdre_pkg::SKIP_MARK;
            run_length_reg   <= '0;
            changed_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            frame_pixels_reg <= frame_pixels_next;
            pos_reg          <= pos_next;
            fill_reg         <= fill_next;
            run_value_reg    <= run_value_next;
            run_length_reg   <= run_length_next;
            changed_reg      <= changed_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rgb_reg         <= rgb_next;
        c_reg           <= c_next;
        len_reg         <= len_next;
        out_byte_reg    <= out_byte_next;
        out_changed_reg <= out_changed_next;
        out_user_reg    <= out_user_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_changed_reg, out_byte_reg};
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- src/fdre_ctrl.sv -----
// Controller of the frame delta run-length encoder: sequences pixel compare,
// run append and the byte flush of a run. Uses fdre_pkg; drives fdre_datapath.
`default_nettype none

module fdre_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              s_kind,
    input  wire fdre_pkg::status_t status,
    output fdre_pkg::cmd_t         cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CMP    = 7'b0000010,
        S_APPEND = 7'b0000100,
        S_FSTART = 7'b0001000,
        S_FLEN   = 7'b0010000,
        S_FHI    = 7'b0100000,
        S_FLO    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    // Low: flushing the run that this pixel ends. High: flushing the frame's final run.
    logic   final_reg, final_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        final_next = final_reg;
        cmd        = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_kind) begin
                        cmd.restart = 1'b1;
                    end else begin
                        cmd.load_pixel = 1'b1;
                        state_next     = S_CMP;
                    end
                end
            end
            S_CMP: begin
                cmd.compare = 1'b1;
                if (status.need_flush) begin
                    final_next = 1'b0;
                    state_next = S_FSTART;
                end else begin
                    cmd.append = 1'b1;
                    if (status.last) begin
                        final_next = 1'b1;
                        state_next = S_FSTART;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_APPEND: begin
                cmd.append = 1'b1;
                if (status.last) begin
                    final_next = 1'b1;
                    state_next = S_FSTART;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_FSTART: begin
                cmd.flush_start = 1'b1;
                state_next      = status.len_needed ? S_FLEN : S_FHI;
            end
            S_FLEN: begin
                if (status.out_free) begin
                    cmd.emit_len = 1'b1;
                    if (status.len_done) begin
                        state_next = status.run_colour ? S_FHI : S_FLO;
                    end
                end
            end
            S_FHI: begin
                if (status.out_free) begin
                    cmd.emit_hi = 1'b1;
                    state_next  = S_FLO;
                end
            end
            S_FLO: begin
                if (status.out_free) begin
                    cmd.emit_lo   = 1'b1;
                    cmd.item_last = final_reg || !status.last;
                    cmd.end_frame = final_reg;
                    if (final_reg) begin
                        cmd.frame_done = 1'b1;
                        state_next     = S_IDLE;
                    end else begin
                        state_next = S_APPEND;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

    // A byte is only produced when the output register can take it.
    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_len || cmd.emit_hi || cmd.emit_lo) |-> status.out_free)
        else $error("byte produced while the output register is occupied");

    // An accepted pixel is compared in the very next cycle.
    a_pixel_to_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_kind) |=> (state_reg == S_CMP))
        else $error("accepted pixel did not reach the compare step");

    // The byte that closes a frame also closes its item and clears the run state.
    a_frame_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.end_frame |-> (cmd.item_last && cmd.frame_done && cmd.emit_lo))
        else $error("frame end not marked as the item's final low byte");

    // A pixel that neither ends a run nor the frame returns from the compare step straight to idle, freeing the input.
    a_quiet_pixel_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP && !status.need_flush && !status.last) |=> s_tready)
        else $error("pixel without output did not finish in two cycles");

endmodule

`default_nettype wire

// ----- src/frame_delta_rle_encoder_top.sv -----
// Top level of the frame delta run-length encoder: joins fdre_ctrl and fdre_datapath.
// Uses fdre_pkg for the command and status structs.
//
// Usage. Pixels enter in raster order on the s_ stream: s_tdata carries the 24-bit
// RGB colour and s_tuser selects a pixel beat (0) or a restart beat (1). Each pixel
// is compared with the stored reference frame; changed pixels become RGB555 and
// update the reference, unchanged pixels become the skip marker. Runs of equal
// values leave as bytes on the m_ stream: m_tuser flags the final byte caused by
// an input beat, m_tlast the final byte of a frame, and on that byte m_tdata also
// carries the frame's changed-pixel count so that downstream logic can drop an
// unchanged frame. The frame size is written through cfg_we/cfg_wdata while idle.
//
// Sequence. A pixel beat that produces no byte first reads the reference memory
// port and then compares and writes back. A pixel that closes a run then sets up
// the flush, sends the run's bytes and opens the next run; the frame's last pixel
// adds another flush set-up and its bytes again. With the default frame memory at
// most 8 bytes follow one beat. On a restart beat, a fill count over the reference
// memory makes unwritten entries read as zero, so no clearing pass is needed, also
// not after reset. Reset empties the output register and clears position, run and
// count. When the receiver stalls, the byte waits in the output register and the
// flush pauses; the input side takes new beats whenever the block is between items.
`default_nettype none

module frame_delta_rle_encoder_top #(
    parameter int MAX_FRAME_PIXELS = 2097152
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Input stream.
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [23:0]               s_tdata,   // [23:0] pixel_rgb
    input  wire logic                      s_tuser,   // [0] kind
    // Frame size register.
    input  wire logic                      cfg_we,
    input  wire logic [fdre_pkg::FP_W-1:0] cfg_wdata, // frame_pixels
    // Encoded byte stream.
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [31:0]                    m_tdata,   // [7:0] out_byte, [29:8] changed_pixels
    output logic                           m_tuser,   // [0] last_of_item
    output logic                           m_tlast    // end_of_frame
);

    fdre_pkg::cmd_t    cmd;
    fdre_pkg::status_t status;

    fdre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    fdre_datapath #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ----- sim/frame_delta_rle_encoder_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of frame_delta_rle_encoder_top: a directed table, then random frames.
// Depends on fdre_pkg and the encoder RTL; it needs nothing else.

module frame_delta_rle_encoder_top_tb;

    localparam int FP_W = fdre_pkg::FP_W;

    // The reference frame is kept small so that whole frames, the clamp of an
    // oversized frame size and the longest runs all fit in a short run.
    localparam int MAX_PIX        = 64;
    localparam int RANDOM_BEATS   = 500;
    localparam int SETTLE_CYCLES  = 16;       // settling wait for a last beat still in the block
    localparam int LONG_HOLD      = 400;      // receiver hold-off that fills the block
    localparam int CYCLE_LIMIT    = 1000000;

    typedef enum logic {
        BEAT_PIXEL   = 1'b0,
        BEAT_RESTART = 1'b1
    } beat_kind_t;

    typedef enum logic [1:0] {
        ROW_PIXEL,
        ROW_RESTART,
        ROW_FRAME_SIZE
    } row_op_t;

    // One encoded byte as it leaves on the m_ stream.
    typedef struct packed {
        logic [7:0]      code_byte;
        logic            item_end;
        logic            frame_end;
        logic [FP_W-1:0] changed;
    } enc_byte_t;

    // One row of the directed table. typed_n < 0: the encoder model decides
    // the bytes; otherwise the next typed_n entries of typed_bytes are used.
    typedef struct packed {
        row_op_t     op;
        logic [23:0] value;
        int          typed_n;
    } dir_row_t;

    logic            aclk = 1'b0;
    logic            aresetn;
    logic            s_tvalid;
    logic            s_tready;
    logic [23:0]     s_tdata;
    logic            s_tuser;
    logic            cfg_we;
    logic [FP_W-1:0] cfg_wdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [31:0]     m_tdata;
    logic            m_tuser;
    logic            m_tlast;

    // Typed byte count of the beat on s_, driven together with s_tdata.
    int              beat_typed_n;

    frame_delta_rle_encoder_top #(
        .MAX_FRAME_PIXELS(MAX_PIX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Encoder model: reference frame, open run and changed count.
    // ------------------------------------------------------------------
    logic [23:0]     ref_frame [MAX_PIX];
    logic [20:0]     cur_pos;
    logic [15:0]     run_val;
    logic [FP_W-1:0] run_len;
    logic [FP_W-1:0] changed_cnt;
    logic [FP_W-1:0] frame_size;

    // Bytes caused by the beat being modeled; at most 5 per beat.
    enc_byte_t       item_bytes [16];
    int              n_item_bytes;

    enc_byte_t       expected_bytes [$];
    enc_byte_t       typed_bytes [$];
    dir_row_t        dir_rows [$];
    int              n_errors = 0;

    // Pacing of the sender (src_idle) and the receiver (sink_idle, hold_req_cnt), chosen per phase.
    int              src_idle;
    int              sink_idle;
    int              hold_req_cnt = 0;

    // A frame size of zero counts as one pixel; anything past the memory is clamped.
    function automatic int unsigned frame_limit(input logic [FP_W-1:0] fp);
        if (fp == '0)
            return 1;
        if (fp > FP_W'(MAX_PIX))
            return MAX_PIX;
        return int'(fp);
    endfunction

    function automatic void clear_run();
        cur_pos     = '0;
        run_val     = fdre_pkg::SKIP_MARK;
        run_len     = '0;
        changed_cnt = '0;
    endfunction

    function automatic void add_item_byte(input logic [7:0] b);
        item_bytes[n_item_bytes] = {b, 1'b0, 1'b0, {FP_W{1'b0}}};
        n_item_bytes++;
    endfunction

    // Close the open run: length groups (lowest first) where needed, then the value.
    function automatic void flush_run();
        logic [FP_W-1:0] rest;
        logic [FP_W-1:0] n;
        logic [FP_W:0]   sum;
        n = run_len;
        if (run_len > 1 || run_val == fdre_pkg::SKIP_MARK) begin
            rest = run_len;
            while (rest != '0) begin
                add_item_byte({fdre_pkg::LEN_TAG, rest[fdre_pkg::LEN_GROUP_W-1:0]});
                rest = rest >> fdre_pkg::LEN_GROUP_W;
            end
        end else begin
            n = FP_W'(1);
        end
        if (run_val != fdre_pkg::SKIP_MARK) begin
            sum = {1'b0, changed_cnt} + {1'b0, n};
            changed_cnt = (sum > {1'b0, fdre_pkg::COUNT_MAX}) ? fdre_pkg::COUNT_MAX
                                                               : sum[FP_W-1:0];
            add_item_byte(run_val[15:8]);
        end
        add_item_byte(run_val[7:0]);
        run_len = '0;
    endfunction

    // Model one accepted input beat; leaves its bytes in item_bytes.
    function automatic void predict_beat(input logic kind, input logic [23:0] rgb);
        int unsigned pos;
        logic [15:0] code;
        enc_byte_t   tail;
        n_item_bytes = 0;
        if (kind == BEAT_RESTART) begin
            foreach (ref_frame[i])
                ref_frame[i] = '0;
            clear_run();
            return;
        end
        pos = (int'(cur_pos) >= MAX_PIX) ? MAX_PIX - 1 : int'(cur_pos);
        if (ref_frame[pos] != rgb) begin
            ref_frame[pos] = rgb;
            code = {1'b0, rgb[23:19], rgb[15:11], rgb[7:3]};
        end else begin
            code = fdre_pkg::SKIP_MARK;
        end
        if (pos > 0 && code != run_val && run_len != '0)
            flush_run();
        if (run_len == '0)
            run_val = code;
        run_len = run_len + FP_W'(1);
        if (pos + 1 >= frame_limit(frame_size)) begin
            flush_run();
            tail = item_bytes[n_item_bytes-1];
            tail.frame_end = 1'b1;
            tail.changed = changed_cnt;
            item_bytes[n_item_bytes-1] = tail;
            clear_run();
        end else begin
            cur_pos = 21'(pos + 1);
        end
        if (n_item_bytes > 0) begin
            tail = item_bytes[n_item_bytes-1];
            tail.item_end = 1'b1;
            item_bytes[n_item_bytes-1] = tail;
        end
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard. Both channels are sampled at the rising edge, before the
    // nonblocking updates of that edge land, so the order of processes in a
    // time step cannot change what is seen. An input beat is modeled first;
    // its bytes can never leave on the edge that accepts it.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        int        i;
        enc_byte_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_beat(s_tuser, s_tdata);
                if (beat_typed_n >= 0) begin
                    repeat (beat_typed_n)
                        expected_bytes.push_back(typed_bytes.pop_front());
                end else begin
                    for (i = 0; i < n_item_bytes; i++)
                        expected_bytes.push_back(item_bytes[i]);
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $error("byte 0x%02h arrived with no byte expected", m_tdata[7:0]);
                    n_errors++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata[7:0] !== want.code_byte) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h",
                               want.code_byte, m_tdata[7:0]);
                        n_errors++;
                    end
                    if (m_tuser !== want.item_end) begin
                        $error("last_of_item: expected %0b, got %0b", want.item_end, m_tuser);
                        n_errors++;
                    end
                    if (m_tlast !== want.frame_end) begin
                        $error("end_of_frame: expected %0b, got %0b", want.frame_end, m_tlast);
                        n_errors++;
                    end
                    if (m_tdata[29:8] !== want.changed) begin
                        $error("changed_pixels: expected %0d, got %0d",
                               want.changed, m_tdata[29:8]);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Mostly short gaps, now and then a long one; rate is in percent.
    function automatic int gap_len(input int rate);
        if ($urandom_range(0, 99) >= rate)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Receiver: random back-pressure, plus a long hold-off whenever the
    // stimulus asks for one, so that the output side fills and s_tready drops.
    initial begin : receiver
        int hold_done;
        int gap;
        hold_done = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_done != hold_req_cnt) begin
                hold_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            gap = gap_len(sink_idle);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Watchdog. The slowest correct run is near 600 beats, each with up to
    // 5 bytes that each wait out the longest receiver gap, the longest sender gap
    // ahead of the beat, the occasional LONG_HOLD hold-offs and the pauses between
    // phases, so CYCLE_LIMIT leaves ample room.
    int cycle_cnt = 0;
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $error("timeout with %0d bytes still expected", expected_bytes.size());
            $display("** frame_delta_rle_encoder_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus side.
    // ------------------------------------------------------------------

    // Offer one beat after an optional gap and hold it until it is taken.
    task automatic send_beat(input beat_kind_t kind, input logic [23:0] rgb,
                             input int typed_n);
        int gap;
        gap = gap_len(src_idle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid     <= 1'b1;
        s_tuser      <= kind;
        s_tdata      <= rgb;
        beat_typed_n <= typed_n;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Stop sending, let every expected byte arrive, then allow for a last
    // beat that produced no byte and may still be in the block. The first
    // edge lets the scoreboard record the bytes of a beat just accepted.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The frame size is only ever written with the block idle.
    task automatic write_frame_size(input logic [FP_W-1:0] fp);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= fp;
        @(posedge aclk);
        frame_size = fp;
        cfg_we    <= 1'b0;
    endtask

    function automatic void add_row(input row_op_t op, input logic [23:0] value,
                                    input int typed_n);
        dir_rows.push_back('{op: op, value: value, typed_n: typed_n});
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic item_end,
                                     input logic frame_end, input int changed);
        typed_bytes.push_back({b, item_end, frame_end, FP_W'(changed)});
    endfunction

    initial begin : stimulus
        dir_row_t    row;
        logic [23:0] gen_hist [MAX_PIX];
        int unsigned gen_pos;
        logic [23:0] last_rgb;
        logic [23:0] rgb;
        logic [FP_W-1:0] fp;
        int          n_sent;
        int          phase_no;
        int          n_phase;
        int          skip_pct;
        int          rep_pct;
        int          r;

        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tuser      <= BEAT_PIXEL;
        s_tdata      <= '0;
        beat_typed_n <= -1;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        src_idle      = 30;
        sink_idle     = 30;

        // State of the encoder model after reset.
        foreach (ref_frame[i])
            ref_frame[i] = '0;
        clear_run();
        frame_size = fdre_pkg::FRAME_PIXELS_RESET;

        // Directed table. With four pixels per frame, the first frame opens a
        // one-pixel skip run, then a two-pixel colour run, and closes with a
        // one-pixel colour run of a pixel that keeps only low colour bits.
        add_row(ROW_FRAME_SIZE, 24'd4, -1);
        add_row(ROW_PIXEL, 24'h000000, -1);
        add_row(ROW_PIXEL, 24'hFFFFFF, 2);
        add_byte(8'h81, 1'b0, 1'b0, 0);
        add_byte(8'hFF, 1'b1, 1'b0, 0);
        add_row(ROW_PIXEL, 24'hFFFFFF, -1);
        add_row(ROW_PIXEL, 24'h070707, 5);
        add_byte(8'h82, 1'b0, 1'b0, 0);
        add_byte(8'h7F, 1'b0, 1'b0, 0);
        add_byte(8'hFF, 1'b0, 1'b0, 0);
        add_byte(8'h00, 1'b0, 1'b0, 0);
        add_byte(8'h00, 1'b1, 1'b1, 3);
        // The same frame again: all skip, so the frame reports no change.
        add_row(ROW_PIXEL, 24'h000000, -1);
        add_row(ROW_PIXEL, 24'hFFFFFF, -1);
        add_row(ROW_PIXEL, 24'hFFFFFF, -1);
        add_row(ROW_PIXEL, 24'h070707, 2);
        add_byte(8'h84, 1'b0, 1'b0, 0);
        add_byte(8'hFF, 1'b1, 1'b1, 0);
        // Restart with no run open, then a restart that drops an open run.
        add_row(ROW_RESTART, 24'hA5A5A5, 0);
        add_row(ROW_PIXEL, 24'h070707, -1);
        add_row(ROW_RESTART, 24'h5A5A5A, -1);
        // Pure red, green and blue on a cleared reference.
        add_row(ROW_PIXEL, 24'hF80000, -1);
        add_row(ROW_PIXEL, 24'h00F800, 2);
        add_byte(8'h7C, 1'b0, 1'b0, 0);
        add_byte(8'h00, 1'b1, 1'b0, 0);
        add_row(ROW_PIXEL, 24'h0000F8, 2);
        add_byte(8'h03, 1'b0, 1'b0, 0);
        add_byte(8'hE0, 1'b1, 1'b0, 0);
        add_row(ROW_PIXEL, 24'h0000F8, 3);
        add_byte(8'h82, 1'b0, 1'b0, 0);
        add_byte(8'h00, 1'b0, 1'b0, 0);
        add_byte(8'h1F, 1'b1, 1'b1, 4);
        // One-pixel frames, then a frame size of zero, which acts as one.
        add_row(ROW_FRAME_SIZE, 24'd1, -1);
        add_row(ROW_PIXEL, 24'h123456, 2);
        add_byte(8'h08, 1'b0, 1'b0, 0);
        add_byte(8'hCA, 1'b1, 1'b1, 1);
        add_row(ROW_PIXEL, 24'h123456, 2);
        add_byte(8'h81, 1'b0, 1'b0, 0);
        add_byte(8'hFF, 1'b1, 1'b1, 0);
        add_row(ROW_FRAME_SIZE, 24'd0, -1);
        add_row(ROW_PIXEL, 24'h000000, 2);
        add_byte(8'h00, 1'b0, 1'b0, 0);
        add_byte(8'h00, 1'b1, 1'b1, 1);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            case (row.op)
                ROW_FRAME_SIZE: begin
                    write_frame_size(row.value[FP_W-1:0]);
                end
                ROW_RESTART: begin
                    send_beat(BEAT_RESTART, row.value, row.typed_n);
                end
                default: begin
                    send_beat(BEAT_PIXEL, row.value, row.typed_n);
                end
            endcase
        end

        // Random phases. Each phase writes a new frame size with the block
        // idle, which often lands in the middle of a frame; the pixel mix
        // favours skips and repeated colours so that long runs build up.
        // The stimulus keeps its own copy of the last frame it sent so that
        // it can repeat a pixel on purpose.
        foreach (gen_hist[i])
            gen_hist[i] = '0;
        gen_pos  = 0;
        last_rgb = '0;
        n_sent   = 0;
        phase_no = 0;
        while (n_sent < RANDOM_BEATS) begin
            case ($urandom_range(0, 11))
                0:       fp = '0;
                1:       fp = 22'd1;
                2:       fp = fdre_pkg::FRAME_PIXELS_RESET;
                3:       fp = {FP_W{1'b1}};
                4:       fp = FP_W'(MAX_PIX);
                5:       fp = FP_W'(MAX_PIX + 1);
                6:       fp = FP_W'($urandom);
                default: fp = FP_W'($urandom_range(2, 16));
            endcase
            write_frame_size(fp);

            case ($urandom_range(0, 3))
                0: begin
                    skip_pct = 3;
                    rep_pct  = 90;
                end
                1: begin
                    skip_pct = 90;
                    rep_pct  = 5;
                end
                default: begin
                    skip_pct = 35;
                    rep_pct  = 30;
                end
            endcase
            src_idle  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
            sink_idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);

            // A long hold-off on the receive side while beats keep coming.
            if (phase_no == 2 || $urandom_range(0, 9) == 0) begin
                src_idle = 0;
                hold_req_cnt++;
            end

            // The first phase starts from a cleared reference to match the copy above.
            if (phase_no == 0) begin
                send_beat(BEAT_RESTART, 24'($urandom), -1);
                n_sent++;
            end

            n_phase = $urandom_range(20, 80);
            repeat (n_phase) begin
                if ($urandom_range(0, 99) < 2) begin
                    send_beat(BEAT_RESTART, 24'($urandom), -1);
                    foreach (gen_hist[i])
                        gen_hist[i] = '0;
                    gen_pos = 0;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < skip_pct)
                        rgb = gen_hist[gen_pos];
                    else if (r < skip_pct + rep_pct)
                        rgb = ($urandom_range(0, 3) == 0) ?
                              last_rgb ^ (24'($urandom) & 24'h070707) : last_rgb;
                    else if (r < skip_pct + rep_pct + 4)
                        rgb = ($urandom_range(0, 1) == 0) ? 24'h000000 : 24'hFFFFFF;
                    else
                        rgb = 24'($urandom);
                    send_beat(BEAT_PIXEL, rgb, -1);
                    last_rgb = rgb;
                    gen_hist[gen_pos] = rgb;
                    gen_pos = (gen_pos + 1 >= frame_limit(frame_size)) ? 0 : gen_pos + 1;
                end
                n_sent++;
            end
            phase_no++;
        end

        drain();
        if (n_errors == 0 && expected_bytes.size() == 0)
            $display("** frame_delta_rle_encoder_top: PASSED **");
        else
            $display("** frame_delta_rle_encoder_top: FAILED **");
        $finish;
    end

endmodule
